/* rtl/bounded_indexed_list_engine_macros.svh */
// assertion macros for the bounded indexed list engine
// used by the modules that carry concurrent assertions; needs clk and rst_n in scope
`ifndef BOUNDED_INDEXED_LIST_ENGINE_MACROS_SVH
`define BOUNDED_INDEXED_LIST_ENGINE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BILE_ASSERT_IMP(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define BILE_ASSERT_NXT(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define BILE_ASSERT_IMP(lbl, a, c)
`define BILE_ASSERT_NXT(lbl, a, c)
`endif
`endif

/* rtl/bile_pkg.sv */
// shared types and codes for the bounded indexed list engine
// no dependencies; used by bile_ctrl, bile_dp and the top level
package bile_pkg;

    localparam logic [3:0] CMD_PUSH_FRONT = 4'd0;
    localparam logic [3:0] CMD_PUSH_BACK  = 4'd1;
    localparam logic [3:0] CMD_POP_FRONT  = 4'd2;
    localparam logic [3:0] CMD_POP_BACK   = 4'd3;
    localparam logic [3:0] CMD_FRONT      = 4'd4;
    localparam logic [3:0] CMD_BACK       = 4'd5;
    localparam logic [3:0] CMD_INSERT     = 4'd6;
    localparam logic [3:0] CMD_ERASE      = 4'd7;
    localparam logic [3:0] CMD_READ       = 4'd8;
    localparam logic [3:0] CMD_READ_END   = 4'd9;
    localparam logic [3:0] CMD_REVERSE    = 4'd10;
    localparam logic [3:0] CMD_REMOVE     = 4'd11;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_RANGE    = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_OPEN  = 3'd1;
    localparam logic [2:0] OP_POP   = 3'd2;
    localparam logic [2:0] OP_ERASE = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;
    localparam logic [2:0] OP_REV   = 3'd5;
    localparam logic [2:0] OP_SCAN  = 3'd6;

    localparam logic [1:0] P_HOLD = 2'd0;
    localparam logic [1:0] P_INIT = 2'd1;
    localparam logic [1:0] P_INC  = 2'd2;
    localparam logic [1:0] P_DEC  = 2'd3;

    localparam logic [1:0] Q_HOLD = 2'd0;
    localparam logic [1:0] Q_INIT = 2'd1;
    localparam logic [1:0] Q_DEC  = 2'd2;

    localparam logic [1:0] RA_P   = 2'd0;
    localparam logic [1:0] RA_PM1 = 2'd1;
    localparam logic [1:0] RA_PP1 = 2'd2;
    localparam logic [1:0] RA_Q   = 2'd3;

    localparam logic WA_P = 1'b0;
    localparam logic WA_Q = 1'b1;

    localparam logic [1:0] WD_VAL   = 2'd0;
    localparam logic [1:0] WD_RDATA = 2'd1;
    localparam logic [1:0] WD_HOLD  = 2'd2;

    typedef struct packed {
        logic       load;
        logic       st_ld;
        logic [1:0] p_op;
        logic [1:0] q_op;
        logic       rd_en;
        logic [1:0] ra_sel;
        logic       wr_en;
        logic       wa_sel;
        logic [1:0] wd_sel;
        logic       hold_ld;
        logic       data_ld;
        logic       len_inc;
        logic       len_dec;
        logic       nf_set;
        logic       res_ld;
    } bile_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       err;
        logic       p_gt_pos;
        logic       p1_lt_len;
        logic       p_lt_q;
        logic       match;
        logic       out_free;
    } bile_stat_t;

endpackage

/* rtl/bounded_indexed_list_engine.sv */
// top level of the bounded indexed list engine
// depends on bile_pkg, bile_ctrl and bile_dp
//
//  channel  handshake              payload
//  cmd      cmd_valid / cmd_ready  command, index, value
//  rsp      rsp_valid / rsp_ready  data, status, count
//
// each item passes accept, decode and result steps plus its memory walk:
// a shift copies each moved element, then finishes (push, insert, pop, erase, remove),
// a read issues and takes the word (pop, front, back, read), reverse swaps each pair,
// remove reads and compares each element probed; a failed command skips the walk
// the result step waits while the previous result is held; after it the next item is taken
// reset empties the list at once; element contents are not cleared
module bounded_indexed_list_engine #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  logic [3:0]         command,
    input  logic [4:0]         index,
    input  logic signed [31:0] value,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output logic signed [31:0] data,
    output logic [2:0]         status,
    output logic [4:0]         count
);
    bile_pkg::bile_cmd_t  ctl;
    bile_pkg::bile_stat_t stat;

    bile_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    bile_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .stat      (stat),
        .command   (command),
        .index     (index),
        .value     (value),
        .data      (data),
        .status    (status),
        .count     (count),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready)
    );
endmodule

/* rtl/bile_dp.sv */
// datapath of the list engine: element memory, pointers, count and result register
// depends on bile_pkg and bounded_indexed_list_engine_macros.svh
`include "bounded_indexed_list_engine_macros.svh"
module bile_dp #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  bile_pkg::bile_cmd_t    ctl,
    output bile_pkg::bile_stat_t   stat,
    input  logic [3:0]             command,
    input  logic [4:0]             index,
    input  logic signed [31:0]     value,
    output logic signed [31:0]     data,
    output logic [2:0]             status,
    output logic [4:0]             count,
    output logic                   rsp_valid,
    input  logic                   rsp_ready
);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int AW   = $clog2(DEPTH);
    localparam int CMPW = (CW > 5) ? CW : 5;

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;
    logic [DATA_WIDTH-1:0] hold_reg;
    logic [DATA_WIDTH-1:0] val_reg;
    logic [DATA_WIDTH-1:0] dat_reg;
    logic [3:0]            cmd_reg;
    logic [4:0]            idx_reg;
    logic [CW-1:0]         len_reg;
    logic [CW-1:0]         p_reg;
    logic [CW-1:0]         q_reg;
    logic [2:0]            err_reg;
    logic                  nf_reg;
    logic                  rsp_valid_reg;
    logic signed [31:0]    data_reg;
    logic [2:0]            status_reg;
    logic [4:0]            count_reg;

    logic signed [63:0]    val_ext;
    logic [63:0]           dat_ext;
    logic [63:0]           len_ext;
    logic [CMPW-1:0]       len_x;
    logic [CMPW-1:0]       idx_x;
    logic [CW-1:0]         idx_c;
    logic [CW-1:0]         len_m1;
    logic [CW-1:0]         p_init;
    logic [CW-1:0]         pos;
    logic [CW-1:0]         ra;
    logic [CW-1:0]         wa;
    logic [DATA_WIDTH-1:0] wd;
    logic [2:0]            err_code;
    logic [2:0]            op;
    logic                  full;
    logic                  empty;

    assign val_ext = 64'(value);
    assign dat_ext = 64'(dat_reg);
    assign len_ext = 64'(len_reg);
    assign len_x   = CMPW'(len_reg);
    assign idx_x   = CMPW'(idx_reg);
    assign idx_c   = CW'(idx_reg);
    assign len_m1  = (len_reg == '0) ? '0 : len_reg - CW'(1);
    assign full    = (len_x == CMPW'(DEPTH));
    assign empty   = (len_reg == '0);

    always_comb
    begin
        err_code = bile_pkg::ST_OK;
        op       = bile_pkg::OP_NONE;
        p_init   = '0;
        pos      = '0;
        case (cmd_reg)
            bile_pkg::CMD_PUSH_FRONT:
            begin
                op       = bile_pkg::OP_OPEN;
                p_init   = len_reg;
                err_code = full ? bile_pkg::ST_FULL : bile_pkg::ST_OK;
            end
            bile_pkg::CMD_PUSH_BACK:
            begin
                op       = bile_pkg::OP_OPEN;
                p_init   = len_reg;
                pos      = len_reg;
                err_code = full ? bile_pkg::ST_FULL : bile_pkg::ST_OK;
            end
            bile_pkg::CMD_INSERT:
            begin
                op     = bile_pkg::OP_OPEN;
                p_init = len_reg;
                pos    = idx_c;
                if (full)
                    err_code = bile_pkg::ST_FULL;
                else if (idx_x > len_x)
                    err_code = bile_pkg::ST_RANGE;
            end
            bile_pkg::CMD_POP_FRONT, bile_pkg::CMD_POP_BACK:
            begin
                op       = bile_pkg::OP_POP;
                p_init   = (cmd_reg == bile_pkg::CMD_POP_BACK) ? len_m1 : '0;
                err_code = empty ? bile_pkg::ST_EMPTY : bile_pkg::ST_OK;
            end
            bile_pkg::CMD_FRONT, bile_pkg::CMD_BACK:
            begin
                op       = bile_pkg::OP_READ;
                p_init   = (cmd_reg == bile_pkg::CMD_BACK) ? len_m1 : '0;
                err_code = empty ? bile_pkg::ST_EMPTY : bile_pkg::ST_OK;
            end
            bile_pkg::CMD_ERASE, bile_pkg::CMD_READ:
            begin
                op     = (cmd_reg == bile_pkg::CMD_ERASE) ? bile_pkg::OP_ERASE
                                                          : bile_pkg::OP_READ;
                p_init = idx_c;
                if (empty)
                    err_code = bile_pkg::ST_EMPTY;
                else if (idx_x >= len_x)
                    err_code = bile_pkg::ST_RANGE;
            end
            bile_pkg::CMD_READ_END:
            begin
                op     = bile_pkg::OP_READ;
                p_init = CW'(len_x - idx_x);
                if (empty)
                    err_code = bile_pkg::ST_EMPTY;
                else if (idx_x == '0 || idx_x > len_x)
                    err_code = bile_pkg::ST_RANGE;
            end
            bile_pkg::CMD_REVERSE:
            begin
                op = bile_pkg::OP_REV;
            end
            bile_pkg::CMD_REMOVE:
            begin
                op       = bile_pkg::OP_SCAN;
                err_code = empty ? bile_pkg::ST_EMPTY : bile_pkg::ST_OK;
            end
            default:
            begin
                op = bile_pkg::OP_NONE;
            end
        endcase
    end

    always_comb
    begin
        case (ctl.ra_sel)
            bile_pkg::RA_PM1: ra = p_reg - CW'(1);
            bile_pkg::RA_PP1: ra = p_reg + CW'(1);
            bile_pkg::RA_Q:   ra = q_reg;
            default:          ra = p_reg;
        endcase
        wa = (ctl.wa_sel == bile_pkg::WA_Q) ? q_reg : p_reg;
        case (ctl.wd_sel)
            bile_pkg::WD_RDATA: wd = rdata_reg;
            bile_pkg::WD_HOLD:  wd = hold_reg;
            default:            wd = val_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
            mem[wa[AW-1:0]] <= wd;
        if (ctl.rd_en)
            rdata_reg <= mem[ra[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= command;
            idx_reg <= index;
            val_reg <= val_ext[DATA_WIDTH-1:0];
            dat_reg <= '0;
        end
        else if (ctl.data_ld)
            dat_reg <= rdata_reg;
        if (ctl.hold_ld)
            hold_reg <= rdata_reg;
        // status is fixed at decode, before the count moves
        if (ctl.st_ld)
            err_reg <= err_code;
        case (ctl.p_op)
            bile_pkg::P_INIT: p_reg <= p_init;
            bile_pkg::P_INC:  p_reg <= p_reg + CW'(1);
            bile_pkg::P_DEC:  p_reg <= p_reg - CW'(1);
            default:          p_reg <= p_reg;
        endcase
        case (ctl.q_op)
            bile_pkg::Q_INIT: q_reg <= len_m1;
            bile_pkg::Q_DEC:  q_reg <= q_reg - CW'(1);
            default:          q_reg <= q_reg;
        endcase
        if (ctl.res_ld)
        begin
            data_reg   <= signed'(dat_ext[31:0]);
            status_reg <= nf_reg ? bile_pkg::ST_NOTFOUND : err_reg;
            count_reg  <= len_ext[4:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            nf_reg        <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.len_inc)
                len_reg <= len_reg + CW'(1);
            else if (ctl.len_dec)
                len_reg <= len_reg - CW'(1);
            if (ctl.load)
                nf_reg <= 1'b0;
            else if (ctl.nf_set)
                nf_reg <= 1'b1;
            if (ctl.res_ld)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    assign stat.op        = op;
    assign stat.err       = (err_code != bile_pkg::ST_OK);
    assign stat.p_gt_pos  = (p_reg > pos);
    assign stat.p1_lt_len = ({1'b0, p_reg} + (CW + 1)'(1)) < {1'b0, len_reg};
    assign stat.p_lt_q    = (p_reg < q_reg);
    assign stat.match     = (rdata_reg == val_reg);
    assign stat.out_free  = !rsp_valid_reg || rsp_ready;

    assign data      = data_reg;
    assign status    = status_reg;
    assign count     = count_reg;
    assign rsp_valid = rsp_valid_reg;

    `BILE_ASSERT_IMP(a_inc_not_full, ctl.len_inc, len_reg < CW'(DEPTH))
    `BILE_ASSERT_IMP(a_dec_not_empty, ctl.len_dec, len_reg != '0)
    `BILE_ASSERT_IMP(a_res_free, ctl.res_ld, !rsp_valid_reg || rsp_ready)
    `BILE_ASSERT_NXT(a_load_clears_nf, ctl.load, !nf_reg)
endmodule

/* rtl/bile_ctrl.sv */
// controller of the list engine: sequences memory reads, writes and pointer steps
// depends on bile_pkg
module bile_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  bile_pkg::bile_stat_t stat,
    output bile_pkg::bile_cmd_t  ctl
);
    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DECODE    = 4'd1;
    localparam logic [3:0] S_OPEN_CHK  = 4'd2;
    localparam logic [3:0] S_OPEN_WR   = 4'd3;
    localparam logic [3:0] S_RD_ISSUE  = 4'd4;
    localparam logic [3:0] S_RD_TAKE   = 4'd5;
    localparam logic [3:0] S_CLOSE_CHK = 4'd6;
    localparam logic [3:0] S_CLOSE_WR  = 4'd7;
    localparam logic [3:0] S_REV_CHK   = 4'd8;
    localparam logic [3:0] S_REV_RDB   = 4'd9;
    localparam logic [3:0] S_REV_WRA   = 4'd10;
    localparam logic [3:0] S_REV_WRB   = 4'd11;
    localparam logic [3:0] S_SCAN_RD   = 4'd12;
    localparam logic [3:0] S_SCAN_CMP  = 4'd13;
    localparam logic [3:0] S_DONE      = 4'd14;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        cmd_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                ctl.st_ld = 1'b1;
                ctl.p_op  = bile_pkg::P_INIT;
                ctl.q_op  = bile_pkg::Q_INIT;
                if (stat.err)
                    state_next = S_DONE;
                else
                begin
                    case (stat.op)
                        bile_pkg::OP_OPEN:  state_next = S_OPEN_CHK;
                        bile_pkg::OP_POP:   state_next = S_RD_ISSUE;
                        bile_pkg::OP_READ:  state_next = S_RD_ISSUE;
                        bile_pkg::OP_ERASE: state_next = S_CLOSE_CHK;
                        bile_pkg::OP_REV:   state_next = S_REV_CHK;
                        bile_pkg::OP_SCAN:  state_next = S_SCAN_RD;
                        default:            state_next = S_DONE;
                    endcase
                end
            end
            S_OPEN_CHK:
            begin
                if (stat.p_gt_pos)
                begin
                    ctl.rd_en  = 1'b1;
                    ctl.ra_sel = bile_pkg::RA_PM1;
                    state_next = S_OPEN_WR;
                end
                else
                begin
                    ctl.wr_en   = 1'b1;
                    ctl.wa_sel  = bile_pkg::WA_P;
                    ctl.wd_sel  = bile_pkg::WD_VAL;
                    ctl.len_inc = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_OPEN_WR:
            begin
                ctl.wr_en  = 1'b1;
                ctl.wa_sel = bile_pkg::WA_P;
                ctl.wd_sel = bile_pkg::WD_RDATA;
                ctl.p_op   = bile_pkg::P_DEC;
                state_next = S_OPEN_CHK;
            end
            S_RD_ISSUE:
            begin
                ctl.rd_en  = 1'b1;
                ctl.ra_sel = bile_pkg::RA_P;
                state_next = S_RD_TAKE;
            end
            S_RD_TAKE:
            begin
                ctl.data_ld = 1'b1;
                state_next  = (stat.op == bile_pkg::OP_POP) ? S_CLOSE_CHK : S_DONE;
            end
            S_CLOSE_CHK:
            begin
                if (stat.p1_lt_len)
                begin
                    ctl.rd_en  = 1'b1;
                    ctl.ra_sel = bile_pkg::RA_PP1;
                    state_next = S_CLOSE_WR;
                end
                else
                begin
                    ctl.len_dec = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_CLOSE_WR:
            begin
                ctl.wr_en  = 1'b1;
                ctl.wa_sel = bile_pkg::WA_P;
                ctl.wd_sel = bile_pkg::WD_RDATA;
                ctl.p_op   = bile_pkg::P_INC;
                state_next = S_CLOSE_CHK;
            end
            S_REV_CHK:
            begin
                if (stat.p_lt_q)
                begin
                    ctl.rd_en  = 1'b1;
                    ctl.ra_sel = bile_pkg::RA_P;
                    state_next = S_REV_RDB;
                end
                else
                    state_next = S_DONE;
            end
            S_REV_RDB:
            begin
                ctl.hold_ld = 1'b1;
                ctl.rd_en   = 1'b1;
                ctl.ra_sel  = bile_pkg::RA_Q;
                state_next  = S_REV_WRA;
            end
            S_REV_WRA:
            begin
                ctl.wr_en  = 1'b1;
                ctl.wa_sel = bile_pkg::WA_P;
                ctl.wd_sel = bile_pkg::WD_RDATA;
                state_next = S_REV_WRB;
            end
            S_REV_WRB:
            begin
                ctl.wr_en  = 1'b1;
                ctl.wa_sel = bile_pkg::WA_Q;
                ctl.wd_sel = bile_pkg::WD_HOLD;
                ctl.p_op   = bile_pkg::P_INC;
                ctl.q_op   = bile_pkg::Q_DEC;
                state_next = S_REV_CHK;
            end
            S_SCAN_RD:
            begin
                ctl.rd_en  = 1'b1;
                ctl.ra_sel = bile_pkg::RA_P;
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                if (stat.match)
                    state_next = S_CLOSE_CHK;
                else if (!stat.p1_lt_len)
                begin
                    ctl.nf_set = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    ctl.p_op   = bile_pkg::P_INC;
                    state_next = S_SCAN_RD;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    ctl.res_ld = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end
endmodule

/* tb/list_checker.sv */
// checker for the bounded indexed list engine: watches both channels,
// predicts each result from its own list model and compares; depends on bile_pkg
`timescale 1ns / 1ps
module list_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  logic               cmd_ready,
    input  logic [3:0]         command,
    input  logic [4:0]         index,
    input  logic signed [31:0] value,
    input  logic               rsp_valid,
    input  logic               rsp_ready,
    input  logic signed [31:0] data,
    input  logic [2:0]         status,
    input  logic [4:0]         count,
    output int                 errors,
    output int                 pending
);
    localparam int CAP   = 16;
    localparam int SLOTS = 64;

    typedef struct packed {
        logic [31:0] data;
        logic [2:0]  status;
        logic [4:0]  count;
    } list_result_t;

    logic [31:0]  cells [CAP];
    int           fill;
    list_result_t exp_mem [SLOTS];
    int           wr_ptr;
    int           rd_ptr;

    task automatic open_cell(input int pos, input logic [31:0] v);
        for (int i = fill; i > pos; i--)
            cells[i] = cells[i-1];
        cells[pos] = v;
        fill++;
    endtask

    task automatic close_cell(input int pos, output logic [31:0] v);
        v = cells[pos];
        for (int i = pos; i + 1 < fill; i++)
            cells[i] = cells[i+1];
        fill--;
    endtask

    task automatic predict(input logic [3:0] cmd, input logic [4:0] idx,
                           input logic [31:0] val, output list_result_t r);
        logic [31:0] d;
        logic [31:0] t;
        logic [2:0]  st;
        bit          hit;
        int          ix;
        d = '0;
        st = bile_pkg::ST_OK;
        ix = int'(idx);
        case (cmd)
            bile_pkg::CMD_PUSH_FRONT, bile_pkg::CMD_PUSH_BACK:
                if (fill >= CAP) st = bile_pkg::ST_FULL;
                else open_cell(cmd == bile_pkg::CMD_PUSH_FRONT ? 0 : fill, val);
            bile_pkg::CMD_POP_FRONT, bile_pkg::CMD_POP_BACK:
                if (fill == 0) st = bile_pkg::ST_EMPTY;
                else close_cell(cmd == bile_pkg::CMD_POP_FRONT ? 0 : fill - 1, d);
            bile_pkg::CMD_FRONT, bile_pkg::CMD_BACK:
                if (fill == 0) st = bile_pkg::ST_EMPTY;
                else d = cells[cmd == bile_pkg::CMD_FRONT ? 0 : fill - 1];
            bile_pkg::CMD_INSERT:
                if (fill >= CAP) st = bile_pkg::ST_FULL;
                else if (ix > fill) st = bile_pkg::ST_RANGE;
                else open_cell(ix, val);
            bile_pkg::CMD_ERASE, bile_pkg::CMD_READ:
                if (fill == 0) st = bile_pkg::ST_EMPTY;
                else if (ix >= fill) st = bile_pkg::ST_RANGE;
                else if (cmd == bile_pkg::CMD_ERASE) close_cell(ix, t);
                else d = cells[ix];
            bile_pkg::CMD_READ_END:
                if (fill == 0) st = bile_pkg::ST_EMPTY;
                else if (ix == 0 || ix > fill) st = bile_pkg::ST_RANGE;
                else d = cells[fill - ix];
            bile_pkg::CMD_REVERSE:
                for (int i = 0; i + 1 < fill - i; i++)
                begin
                    t = cells[i];
                    cells[i] = cells[fill-1-i];
                    cells[fill-1-i] = t;
                end
            bile_pkg::CMD_REMOVE:
                if (fill == 0) st = bile_pkg::ST_EMPTY;
                else
                begin
                    st = bile_pkg::ST_NOTFOUND;
                    hit = 0;
                    for (int i = 0; i < fill && !hit; i++)
                        if (cells[i] == val)
                        begin
                            close_cell(i, t);
                            st = bile_pkg::ST_OK;
                            hit = 1;
                        end
                end
            default: ;
        endcase
        r.data = d;
        r.status = st;
        r.count = 5'(fill);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        list_result_t r;
        list_result_t e;
        int           bad;
        bad = 0;
        if (!rst_n)
        begin
            fill = 0;
            errors <= 0;
            wr_ptr <= 0;
            rd_ptr <= 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (wr_ptr == rd_ptr)
                begin
                    $error("result item with no expectation");
                    bad++;
                end
                else
                begin
                    e = exp_mem[rd_ptr % SLOTS];
                    rd_ptr <= rd_ptr + 1;
                    if (data !== e.data)
                    begin
                        $error("data expected %h actual %h", e.data, data);
                        bad++;
                    end
                    if (status !== e.status)
                    begin
                        $error("status expected %0d actual %0d", e.status, status);
                        bad++;
                    end
                    if (count !== e.count)
                    begin
                        $error("count expected %0d actual %0d", e.count, count);
                        bad++;
                    end
                end
            end
            if (cmd_valid && cmd_ready)
            begin
                predict(command, index, value, r);
                exp_mem[wr_ptr % SLOTS] <= r;
                wr_ptr <= wr_ptr + 1;
            end
            if (bad != 0)
                errors <= errors + bad;
        end
    end

    assign pending = wr_ptr - rd_ptr;
endmodule

/* tb/testbench.sv */
// stimulus and verdict for the bounded indexed list engine
// depends on bile_pkg, the engine rtl and list_checker
`timescale 1ns / 1ps
module testbench;
    logic               clk = 0;
    logic               rst_n = 0;
    logic               cmd_valid = 0;
    logic               cmd_ready;
    logic [3:0]         command = '0;
    logic [4:0]         index = '0;
    logic signed [31:0] value = '0;
    logic               rsp_valid;
    logic               rsp_ready = 0;
    logic signed [31:0] data;
    logic [2:0]         status;
    logic [4:0]         count;
    int                 errors;
    int                 pending;

    int idle_pct = 0;
    int stall_pct = 0;
    int quiet = 0;
    int tb_fill = 0;
    logic [31:0] recent [8];

    localparam int QUIET_LIMIT = 20000;

    always #4 clk = ~clk;

    bounded_indexed_list_engine DUT (.*);

    list_checker checker_i (.*);

    always @(posedge clk)
        if (rst_n)
            rsp_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_item(input logic [3:0] c, input logic [4:0] i,
                             input logic [31:0] v);
        while ($urandom_range(99) < idle_pct)
        begin
            cmd_valid <= 0;
            @(posedge clk);
        end
        command <= c;
        index <= i;
        value <= v;
        cmd_valid <= 1;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(4))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return recent[$urandom_range(7)];
            default: return $urandom();
        endcase
    endfunction

    task automatic random_item();
        logic [3:0]  c;
        logic [4:0]  i;
        logic [31:0] v;
        int          r;
        r = $urandom_range(99);
        if (r < 2) c = 4'($urandom_range(15, 12));
        else if (tb_fill < 8 && r < 45) c = 4'($urandom_range(1));
        else if (r < 20) c = 4'($urandom_range(1));
        else c = 4'($urandom_range(11, 2));
        i = ($urandom_range(9) == 0) ? 5'($urandom()) : 5'($urandom_range(tb_fill + 1));
        v = pick_value();
        if (c <= bile_pkg::CMD_PUSH_BACK || c == bile_pkg::CMD_INSERT)
            recent[$urandom_range(7)] = v;
        send_item(c, i, v);
        if ((c <= bile_pkg::CMD_PUSH_BACK || (c == bile_pkg::CMD_INSERT && i <= tb_fill))
            && tb_fill < 16)
            tb_fill++;
        else if ((c == bile_pkg::CMD_POP_FRONT || c == bile_pkg::CMD_POP_BACK) && tb_fill > 0)
            tb_fill--;
        else if (c == bile_pkg::CMD_ERASE && i < tb_fill)
            tb_fill--;
        else if (c == bile_pkg::CMD_REMOVE && tb_fill > 0 && $urandom_range(1))
            tb_fill = int'(count);
    endtask

    initial
    begin
        foreach (recent[k]) recent[k] = $urandom();
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // empty list errors, then filling past full, range errors, reverse, remove and an unknown command
        send_item(bile_pkg::CMD_POP_FRONT, 5'd0, 32'd0);
        send_item(bile_pkg::CMD_POP_BACK, 5'd0, 32'd0);
        send_item(bile_pkg::CMD_FRONT, 5'd0, 32'd0);
        send_item(bile_pkg::CMD_BACK, 5'd0, 32'd0);
        send_item(bile_pkg::CMD_ERASE, 5'd0, 32'd0);
        send_item(bile_pkg::CMD_READ, 5'd0, 32'd0);
        send_item(bile_pkg::CMD_READ_END, 5'd1, 32'd0);
        send_item(bile_pkg::CMD_REMOVE, 5'd0, 32'd0);
        send_item(bile_pkg::CMD_REVERSE, 5'd0, 32'd0);
        send_item(bile_pkg::CMD_INSERT, 5'd1, 32'd5);
        send_item(bile_pkg::CMD_INSERT, 5'd0, 32'h8000_0000);
        send_item(bile_pkg::CMD_PUSH_BACK, 5'd0, 32'h7fff_ffff);
        send_item(bile_pkg::CMD_INSERT, 5'd2, 32'hffff_ffff);
        for (int k = 0; k < 14; k++) send_item(bile_pkg::CMD_PUSH_FRONT, 5'd31, 32'(k));
        send_item(bile_pkg::CMD_PUSH_BACK, 5'd0, 32'd1);
        send_item(bile_pkg::CMD_INSERT, 5'd0, 32'd1);
        send_item(bile_pkg::CMD_READ, 5'd16, 32'd0);
        send_item(bile_pkg::CMD_READ_END, 5'd0, 32'd0);
        send_item(bile_pkg::CMD_READ_END, 5'd16, 32'd0);
        send_item(bile_pkg::CMD_REVERSE, 5'd0, 32'd0);
        send_item(bile_pkg::CMD_REMOVE, 5'd0, 32'h7fff_ffff);
        send_item(bile_pkg::CMD_REMOVE, 5'd0, 32'h1234_5678);
        send_item(4'd15, 5'd31, 32'hffff_ffff);
        cmd_valid <= 0;
        tb_fill = 15;
        // pause until every result has come
        while (pending != 0) @(posedge clk);
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 54 : 35) : 0;
            stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 54 : 35) : 0;
            for (int n = 0; n < 430; n++) random_item();
        end
        cmd_valid <= 0;
        stall_pct = 0;
        while (pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

/* files.f */
+incdir+rtl
rtl/bile_pkg.sv
rtl/bile_dp.sv
rtl/bile_ctrl.sv
rtl/bounded_indexed_list_engine.sv
tb/list_checker.sv
tb/testbench.sv
